FILE: hdl/gwm_pkg.sv
package gwm_pkg;

    // Pattern bytes with a special meaning.
    localparam logic [7:0] STAR_CODE  = 8'd42;
    localparam logic [7:0] QMARK_CODE = 8'd63;

    // Number of pattern bytes the pattern register holds.
    localparam int CHARS_HELD = 8;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_PATTERN_CHARS  = 1'b0,
        CFG_PATTERN_LENGTH = 1'b1
    } t_cfg_index;

    // Folds A-Z to lower case and leaves every other byte as it is.
    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'd65 && c <= 8'd90) begin
            r = c + 8'd32;
        end
        return r;
    endfunction

endpackage

FILE: hdl/gwm_step.sv
module gwm_step #(
    parameter int NPOS = 8
) (
    input  logic [NPOS:0] i_active,
    input  logic [63:0]   i_pattern,
    input  logic [3:0]    i_len,
    input  logic [7:0]    i_char,
    input  logic          i_has,
    output logic [NPOS:0] o_next,
    output logic          o_matched
);
    import gwm_pkg::*;

    logic [NPOS:0]   pos_mask;
    logic [NPOS:0]   last_pos;
    logic [NPOS-1:0] used;
    logic [NPOS-1:0] is_star;
    logic [NPOS-1:0] hit;
    logic [NPOS:0]   closed;
    logic [NPOS:0]   advanced;
    logic [NPOS:0]   reclosed;
    logic [NPOS:0]   result_set;

    // Decode the position masks from the effective pattern length.
    always_comb begin
        for (int k = 0; k <= NPOS; k++) begin
            pos_mask[k] = (4'(k) <= i_len);
            last_pos[k] = (4'(k) == i_len);
        end
    end

    // Classify each pattern byte against the incoming character.
    always_comb begin
        for (int k = 0; k < NPOS; k++) begin
            used[k]    = (4'(k) < i_len);
            is_star[k] = (i_pattern[8*k +: 8] == STAR_CODE);
            hit[k]     = (i_pattern[8*k +: 8] == QMARK_CODE) ||
                         (fold_case(i_pattern[8*k +: 8]) == fold_case(i_char));
        end
    end

    // Star closure of the stored set: a reachable star also reaches the next position.
    always_comb begin
        closed = i_active & pos_mask;
        for (int k = 0; k < NPOS; k++) begin
            if (used[k] && closed[k] && is_star[k]) begin
                closed[k+1] = 1'b1;
            end
        end
    end

    // Consume one character: a star keeps its position, a hit moves one on.
    always_comb begin
        advanced = '0;
        for (int k = 0; k < NPOS; k++) begin
            if (used[k] && closed[k]) begin
                if (is_star[k]) begin
                    advanced[k] = 1'b1;
                end else if (hit[k]) begin
                    advanced[k+1] = 1'b1;
                end
            end
        end
        advanced = advanced & pos_mask;
    end

    // Star closure again after the character has been consumed.
    always_comb begin
        reclosed = advanced;
        for (int k = 0; k < NPOS; k++) begin
            if (used[k] && reclosed[k] && is_star[k]) begin
                reclosed[k+1] = 1'b1;
            end
        end
    end

    assign result_set = i_has ? reclosed : closed;
    assign o_next     = result_set;
    assign o_matched  = |(result_set & last_pos);

endmodule

FILE: hdl/glob_wildcard_matcher.sv
// An accepted item is held in the input register, and the match result of an end
// item is shown from the result register.
// Throughput: one item per cycle unless an end item waits behind a blocked result;
// the active-position update and its star closure settle combinationally between the two registers.
// Reset (synchronous, active low): only pattern position 0 is active, both
// configuration registers are cleared and no item or result is held.
module glob_wildcard_matcher #(
    parameter int PATTERN_LEN = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [0:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_char_code,
    input  logic        i_has_char,
    input  logic        i_end_of_string,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_matched
);
    import gwm_pkg::*;

    // Positions beyond the bytes the pattern register holds are never used.
    localparam int NPOS = (PATTERN_LEN < CHARS_HELD) ? PATTERN_LEN : CHARS_HELD;

    logic [63:0]   r_pattern;
    logic [3:0]    r_len;
    logic [NPOS:0] r_active;
    logic [NPOS:0] n_active;
    logic          r_in_vld;
    logic [7:0]    r_char;
    logic          r_has;
    logic          r_end;
    logic          r_out_vld;
    logic          n_out_vld;
    logic          r_matched;
    logic [3:0]    eff_len;
    logic [NPOS:0] step_next;
    logic          step_matched;
    logic          fire;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= '0;
            r_len     <= '0;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_PATTERN_CHARS:  r_pattern <= i_cfg_data;
                CFG_PATTERN_LENGTH: r_len     <= i_cfg_data[3:0];
                default:            r_len     <= r_len;
            endcase
        end
    end

    assign eff_len = (r_len > 4'(NPOS)) ? 4'(NPOS) : r_len;

    // The held item moves on unless it is an end item and the result is blocked.
    assign fire       = r_in_vld && (!r_end || !r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || fire;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_char <= i_char_code;
            r_has  <= i_has_char;
            r_end  <= i_end_of_string;
        end
    end

    gwm_step #(
        .NPOS (NPOS)
    ) u_step (
        .i_active  (r_active),
        .i_pattern (r_pattern),
        .i_len     (eff_len),
        .i_char    (r_char),
        .i_has     (r_has),
        .o_next    (step_next),
        .o_matched (step_matched)
    );

    // Active-position update: an end item restarts, an empty item leaves it alone.
    always_comb begin
        n_active = r_active;
        if (fire) begin
            if (r_end) begin
                n_active = (NPOS+1)'(1);
            end else if (r_has) begin
                n_active = step_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= (NPOS+1)'(1);
        end else begin
            r_active <= n_active;
        end
    end

    // Result register.
    always_comb begin
        n_out_vld = r_out_vld && !i_out_ready;
        if (fire && r_end) begin
            n_out_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && r_end) begin
            r_matched <= step_matched;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_matched   = r_matched;

endmodule

FILE: hdl/gwm_checker.sv
module gwm_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input logic o_matched
);

    // A result that is not taken stays on the port unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_matched))
        else $error("result dropped or changed while stalled");

    // The block leaves reset with no result on show.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid straight after reset");

    // The input side only stalls behind a result that is waiting to be taken.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input stalled without a blocked result");

endmodule

bind glob_wildcard_matcher gwm_checker u_gwm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_matched   (o_matched)
);

FILE: sim/tb_glob_wildcard_matcher.sv
module tb_glob_wildcard_matcher;
    timeunit 1ns;
    timeprecision 1ps;

    import gwm_pkg::*;

    localparam int PAT_LEN       = 8;
    localparam int ITEM_TARGET   = 1900;
    localparam int CALM_FROM     = 1600;
    localparam int SETTLE_CYCLES = 6;

    // Keeps its own copy of the pattern and the reachable positions, and the match
    // results still owed by the block.
    class match_scoreboard;
        logic [63:0]      pat_chars;
        logic [3:0]       pat_len;
        logic [PAT_LEN:0] reach;
        bit               expected_matches[$];
        int               n_mismatch;
        int               n_fail;

        function new();
            pat_chars  = '0;
            pat_len    = '0;
            reach      = (PAT_LEN + 1)'(1);
            n_mismatch = 0;
            n_fail     = 0;
        endfunction

        function void write_reg(t_cfg_index idx, logic [63:0] data);
            if (idx == CFG_PATTERN_CHARS) begin
                pat_chars = data;
            end else begin
                pat_len = data[3:0];
            end
        endfunction

        // Pattern length in use, limited by the parameter and the register size.
        function int unsigned active_len();
            int unsigned n;
            n = pat_len;
            if (n > PAT_LEN) n = PAT_LEN;
            if (n > CHARS_HELD) n = CHARS_HELD;
            return n;
        endfunction

        function logic [7:0] lower(logic [7:0] c);
            return (c >= 8'd65 && c <= 8'd90) ? c + 8'd32 : c;
        endfunction

        // A reachable star also makes the position after it reachable.
        function logic [PAT_LEN:0] star_close(logic [PAT_LEN:0] s, int unsigned n);
            s &= ~({(PAT_LEN + 1){1'b1}} << (n + 1));
            for (int i = 0; i < n; i++) begin
                if (s[i] && pat_chars[8*i +: 8] == STAR_CODE) s[i+1] = 1'b1;
            end
            return s;
        endfunction

        // Moves every reachable position over one string character.
        function logic [PAT_LEN:0] consume(logic [PAT_LEN:0] s, int unsigned n,
                                           logic [7:0] ch);
            logic [PAT_LEN:0] nxt;
            logic [7:0]       p;
            nxt = '0;
            for (int i = 0; i < n; i++) begin
                if (s[i]) begin
                    p = pat_chars[8*i +: 8];
                    if (p == STAR_CODE) begin
                        nxt[i] = 1'b1;
                    end else if (p == QMARK_CODE || lower(p) == lower(ch)) begin
                        nxt[i+1] = 1'b1;
                    end
                end
            end
            return nxt;
        endfunction

        function void note_item(logic [7:0] ch, logic has, logic eos);
            int unsigned      n;
            logic [PAT_LEN:0] s;
            n = active_len();
            s = star_close(reach, n);
            if (has) s = star_close(consume(s, n, ch), n);
            if (!eos) begin
                if (has) reach = s;
                return;
            end
            expected_matches.insert(expected_matches.size(), s[n]);
            reach = (PAT_LEN + 1)'(1);
        endfunction

        function void check_result(logic got);
            bit want;
            if (expected_matches.size() == 0) begin
                n_fail++;
                if (n_mismatch < 10) $display("unexpected match result %b", got);
                n_mismatch++;
                return;
            end
            want = expected_matches.pop_front();
            if (got !== want) begin
                n_fail++;
                if (n_mismatch < 10) $display("matched: expected %b, got %b", want, got);
                n_mismatch++;
            end
        endfunction

        function int pending();
            return expected_matches.size();
        endfunction

        function void check_leftover();
            if (expected_matches.size() != 0) begin
                n_fail++;
                $display("%0d match results never arrived", expected_matches.size());
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [0:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  char_code;
    logic        has_char;
    logic        end_of_string;
    logic        out_valid;
    logic        out_ready;
    logic        matched;

    match_scoreboard sb;
    int gap_pct;
    int stall_pct;
    int items_sent;

    glob_wildcard_matcher #(
        .PATTERN_LEN(PAT_LEN)
    ) u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_char_code    (char_code),
        .i_has_char     (has_char),
        .i_end_of_string(end_of_string),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_matched      (matched)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Generous limit for the slowest correct run.
    initial begin
        #2_000_000;
        $display("FAIL glob_wildcard_matcher");
        $finish;
    end

    // Result side stalls in random bursts.
    initial begin : result_stalls
        int n;
        out_ready = 1'b1;
        forever begin
            @(negedge clk);
            if ($urandom_range(99) < stall_pct) begin
                n = $urandom_range(1, 18);
                out_ready <= 1'b0;
                repeat (n) @(negedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    // Register writes, accepted items and results are all seen at the rising edge.
    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_wr_en) sb.write_reg(t_cfg_index'(cfg_index), cfg_data);
            if (in_valid && in_ready) sb.note_item(char_code, has_char, end_of_string);
            if (out_valid && out_ready) sb.check_result(matched);
        end
    end

    task automatic send_item(input logic [7:0] c, input logic h, input logic e);
        int gap;
        @(negedge clk);
        if ($urandom_range(99) < gap_pct) begin
            gap = $urandom_range(1, 18);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid      <= 1'b1;
        char_code     <= c;
        has_char      <= h;
        end_of_string <= e;
        do @(posedge clk); while (in_ready !== 1'b1);
        if (h || e) items_sent++;
    endtask

    // Sends a string, with the odd ignored item mixed in. The end comes either on
    // the last character or as a separate item without a character.
    task automatic send_string(input logic [7:0] s[$], input bit tail_end);
        for (int i = 0; i < s.size(); i++) begin
            if ($urandom_range(99) < 4) send_item(8'($urandom_range(255)), 1'b0, 1'b0);
            send_item(s[i], 1'b1, !tail_end && i == s.size() - 1);
        end
        if (tail_end || s.size() == 0) begin
            send_item(8'($urandom_range(255)), 1'b0, 1'b1);
        end
    endtask

    task automatic send_text(input string t, input bit tail_end);
        logic [7:0] q[$];
        for (int i = 0; i < t.len(); i++) q.insert(q.size(), t[i]);
        send_string(q, tail_end);
    endtask

    // Holds the input back until every owed result is in and the block has settled.
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_pattern(input logic [63:0] chars, input logic [3:0] len);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_PATTERN_CHARS;
        cfg_data  <= chars;
        @(negedge clk);
        cfg_index <= CFG_PATTERN_LENGTH;
        cfg_data  <= {60'd0, len};
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [63:0] text_pattern(input string t);
        logic [63:0] r;
        r = '0;
        for (int i = 0; i < t.len() && i < 8; i++) r[8*i +: 8] = t[i];
        return r;
    endfunction

    function automatic logic [7:0] pick_letter();
        logic [7:0] c;
        c = 8'h61 + 8'($urandom_range(0, 2));
        if ($urandom_range(1) == 1) c -= 8'd32;
        return c;
    endfunction

    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(99);
        if (r < 12) return 8'($urandom_range(255));
        if (r < 20) return STAR_CODE;
        return pick_letter();
    endfunction

    function automatic logic [7:0] pick_pattern_byte();
        int r;
        r = $urandom_range(99);
        if (r < 30) return STAR_CODE;
        if (r < 50) return QMARK_CODE;
        if (r < 88) return pick_letter();
        return 8'($urandom_range(255));
    endfunction

    initial begin : stimulus
        logic [63:0] chars;
        logic [3:0]  len;
        logic [7:0]  q[$];
        logic [7:0]  p;
        int unsigned n;
        int          k;

        sb            = new();
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = CFG_PATTERN_CHARS;
        cfg_data      = '0;
        in_valid      = 1'b0;
        char_code     = '0;
        has_char      = 1'b0;
        end_of_string = 1'b0;
        gap_pct       = 0;
        stall_pct     = 0;
        items_sent    = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Empty pattern after reset: only the empty string matches.
        q = {};
        send_string(q, 1'b1);
        send_text("x", 1'b0);

        // Star, question mark and folded literals, plus an ignored item mid-string.
        wait_idle();
        load_pattern(text_pattern("A*?z"), 4'd4);
        send_text("abz", 1'b0);
        send_item("A", 1'b1, 1'b0);
        send_item("q", 1'b1, 1'b0);
        send_item("x", 1'b0, 1'b0);
        send_item("Z", 1'b1, 1'b0);
        send_item("0", 1'b0, 1'b1);
        send_text("a", 1'b1);

        // A star in the string is an ordinary character.
        wait_idle();
        load_pattern(text_pattern("a?c"), 4'd3);
        send_text("a*c", 1'b0);

        // Bytes next to the letter ranges do not fold.
        wait_idle();
        load_pattern(text_pattern("@["), 4'd2);
        send_text("`{", 1'b0);

        // Length register above the pattern size saturates.
        wait_idle();
        load_pattern(text_pattern("ab*****?"), 4'd15);
        send_text("abx", 1'b0);

        // Extreme byte values.
        wait_idle();
        load_pattern(64'h0000_0000_0000_00ff, 4'd2);
        q = {8'hff, 8'h00};
        send_string(q, 1'b0);

        // Pattern shortened in the middle of a string.
        wait_idle();
        load_pattern(text_pattern("ab"), 4'd2);
        send_item("a", 1'b1, 1'b0);
        wait_idle();
        load_pattern(text_pattern("ab"), 4'd1);
        send_item("b", 1'b0, 1'b1);

        // Random phases, each with its own pattern and idling density.
        while (items_sent < ITEM_TARGET) begin
            wait_idle();
            if ($urandom_range(9) == 0) begin
                chars = {$urandom, $urandom};
            end else begin
                for (int i = 0; i < 8; i++) chars[8*i +: 8] = pick_pattern_byte();
            end
            len = ($urandom_range(99) < 85) ? 4'($urandom_range(0, 8))
                                            : 4'($urandom_range(9, 15));
            load_pattern(chars, len);
            n = (len > 8) ? 8 : len;

            if (items_sent >= CALM_FROM) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else begin
                case ($urandom_range(3))
                    0: begin gap_pct = 0;  stall_pct = 0;  end
                    1: begin gap_pct = 10; stall_pct = 3;  end
                    2: begin gap_pct = 40; stall_pct = 15; end
                    default: begin gap_pct = 5; stall_pct = 30; end
                endcase
            end

            k = $urandom_range(8, 30);
            while (k > 0 && items_sent < ITEM_TARGET) begin
                q = {};
                if ($urandom_range(99) < 80) begin
                    // A string shaped after the pattern, sometimes damaged.
                    for (int i = 0; i < n; i++) begin
                        p = chars[8*i +: 8];
                        if (p == STAR_CODE) begin
                            repeat ($urandom_range(0, 3)) q.insert(q.size(), pick_char());
                        end else if (p == QMARK_CODE) begin
                            q.insert(q.size(), 8'($urandom_range(255)));
                        end else begin
                            if (((p >= "a" && p <= "z") || (p >= "A" && p <= "Z"))
                                && $urandom_range(1) == 1) begin
                                p ^= 8'h20;
                            end
                            q.insert(q.size(), p);
                        end
                    end
                    if ($urandom_range(99) < 25) begin
                        case ($urandom_range(2))
                            0: if (q.size() > 0) q[$urandom_range(q.size() - 1)] = pick_char();
                            1: if (q.size() > 0) q.delete($urandom_range(q.size() - 1));
                            default: q.insert($urandom_range(q.size()), pick_char());
                        endcase
                    end
                end else begin
                    repeat ($urandom_range(0, 10)) q.insert(q.size(), pick_char());
                end
                send_string(q, $urandom_range(99) < 30);
                k--;
            end
        end

        // Drain and finish.
        gap_pct   = 0;
        stall_pct = 0;
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        sb.check_leftover();
        if (sb.n_fail == 0) begin
            $display("PASS glob_wildcard_matcher");
        end else begin
            $display("FAIL glob_wildcard_matcher");
        end
        $finish;
    end

endmodule
